FILE: rtl/ntc_pkg.sv
// Package for the NTC table temperature converter: widths, register codes, ROM tables.
package ntc_pkg;

  localparam int unsigned RawW  = 24;
  localparam int unsigned TempW = 20;
  localparam int unsigned SelW  = 3;
  localparam int unsigned KeyW  = 23;
  localparam int unsigned DegW  = 10;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned ScaleDefault = 1000;

  localparam logic [1:0] RegTableSel = 2'd0;
  localparam logic [1:0] RegDefault  = 2'd1;
  localparam logic [1:0] RegMin      = 2'd2;
  localparam logic [1:0] RegMax      = 2'd3;

  localparam logic [SelW-1:0] NumTables = 3'd4;

  typedef struct packed {
    logic [KeyW-1:0]        key;
    logic signed [DegW-1:0] deg;
  } entry_t;

  localparam int unsigned LenR   = 166;
  localparam int unsigned LenV10 = 166;
  localparam int unsigned LenV12 = 166;
  localparam int unsigned LenV18 = 32;

  localparam int RKey [LenR] = '{
    2561,2634,2709,2787,2868,2952,3038,3128,3220,3316,3415,3518,3624,3734,3848,3966,
    3966,4215,4346,4482,4623,4769,4921,5078,5241,5410,5586,5768,5957,6153,6357,6568,
    6788,7016,7254,7500,7756,8022,8299,8587,8887,9198,9522,9859,10210,10580,10960,
    11350,11760,12190,12640,13110,13600,14100,14630,15180,15760,16360,16990,17640,
    18320,19040,19780,20560,21370,22220,23110,24040,25010,26030,27090,28200,29360,
    30580,31860,33190,34600,36060,37600,39210,40900,42670,44530,46490,48530,50680,
    52940,55310,57810,60420,63180,66070,69120,72320,75690,79230,82970,86900,91040,
    95400,100000,104800,110000,115400,121000,127000,133400,140100,147200,154600,
    162500,170900,179700,189000,198900,209400,220500,232200,244700,257800,271800,
    286700,302400,319100,336800,355600,375600,396900,419500,443500,469100,496300,
    525300,556200,589000,624100,661500,701300,743900,789300,837800,889600,945000,
    1004000,1068000,1135000,1208000,1286000,1369000,1458000,1554000,1656000,1767000,
    1885000,2012000,2149000,2296000,2454000,2624000,2807000,3005000,3218000,3447000,
    3695000,3962000,4251000};

  localparam int V10Key [LenV10] = '{
    208,218,217,222,227,232,237,242,247,253,259,264,270,277,283,289,296,303,310,317,
    324,332,340,347,356,364,373,381,391,400,409,419,429,439,450,461,472,483,495,507,
    519,532,545,558,572,586,600,614,630,645,661,677,694,711,728,746,765,783,802,822,
    842,863,884,905,927,950,973,996,1020,1045,1070,1095,1122,1148,1175,1203,1231,
    1260,1289,1319,1349,1380,1411,1443,1475,1508,1541,1575,1609,1643,1678,1714,1750,
    1786,1822,1859,1896,1934,1972,2010,2048,2086,2125,2164,2203,2242,2281,2321,2360,
    2399,2438,2476,2515,2554,2593,2631,2669,2707,2745,2782,2819,2856,2892,2927,2963,
    2997,3032,3066,3099,3131,3164,3195,3226,3256,3286,3315,3343,3371,3398,3425,3451,
    3476,3500,3524,3547,3569,3591,3612,3633,3653,3672,3690,3708,3726,3742,3758,3774,
    3789,3803,3817,3831,3843,3856,3867,3879,3890};

  localparam int V12Key [LenV12] = '{
    175,178,182,186,191,195,199,204,208,213,218,223,228,233,238,244,250,255,261,268,
    274,280,287,294,301,308,315,323,331,338,347,355,364,373,382,391,401,411,421,431,
    442,453,464,486,488,500,512,525,539,552,566,580,595,610,626,641,658,674,691,709,
    727,745,764,783,803,823,844,866,887,909,932,955,979,1004,1029,1054,1080,1107,
    1134,1161,1189,1218,1247,1277,1308,1339,1370,1402,1435,1468,1501,1535,1570,1605,
    1640,1676,1713,1749,1786,1824,1862,1900,1938,1977,2017,2056,2096,2135,2175,2215,
    2255,2295,2335,2376,2416,2455,2495,2535,2575,2614,2653,2692,2731,2769,2807,2845,
    2882,2919,2955,2990,3026,3060,3095,3128,3161,3193,3225,3256,3286,3316,3345,3373,
    3401,3428,3454,3480,3505,3529,3552,3575,3597,3619,3639,3659,3679,3697,3716,3733,
    3750,3766,3782,3796,3811,3825,3838,3851};

  localparam int V18Key [LenV18] = '{
    0,110,313,406,531,590,655,729,812,903,1001,1111,1230,1360,1497,1646,1803,1967,
    2136,2308,2480,2650,2814,2973,3122,3261,3387,3500,3602,3689,3764,4095};
  localparam int V18Deg [LenV18] = '{
    0,125,84,74,64,60,56,52,48,44,40,36,32,28,24,20,16,12,8,4,0,-4,-8,-12,-16,-20,
    -24,-28,-32,-36,-40,-273};

  // Table length per selector; zero for no table
  function automatic logic [IdxW:0] tab_len(input logic [SelW-1:0] sel);
    logic [IdxW:0] n;
    case (sel)
      3'd0:    n = (IdxW+1)'(LenR);
      3'd1:    n = (IdxW+1)'(LenV10);
      3'd2:    n = (IdxW+1)'(LenV12);
      3'd3:    n = (IdxW+1)'(LenV18);
      default: n = '0;
    endcase
    return n;
  endfunction

  // ROM read: tables r, v10, v12 run 125 down by one degree per entry
  function automatic entry_t tab_entry(input logic [SelW-1:0] sel,
                                       input logic [IdxW-1:0] idx);
    entry_t e;
    int     i;
    i = int'(idx);
    e.key = '0;
    e.deg = DegW'(125 - i);
    case (sel)
      3'd0: if (i < LenR) e.key = KeyW'(RKey[i]);
      3'd1: if (i < LenV10) e.key = KeyW'(V10Key[i]);
      3'd2: if (i < LenV12) e.key = KeyW'(V12Key[i]);
      3'd3: if (i < LenV18) begin
        e.key = KeyW'(V18Key[i]);
        e.deg = DegW'(V18Deg[i]);
      end
      default: e.key = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/ntc_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned.
module ntc_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DenW+1]) begin
        rem_d  = diff[DenW:0];
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && cnt_q == CntW'(1);
  assign quot_o = quot_d;
endmodule

FILE: rtl/ntc_table_temperature_convert.sv
// Top level of the NTC table temperature converter: sequencer, search, divide, range check.
// Converts one raw thermistor reading (ADC code or resistance, 24-bit signed) into a
// temperature in degrees times Scale through one of four constant ROM tables picked by
// the table_select register. Readings past either end of a table give that end's
// temperature, exact key hits give the entry's temperature, and anything in between is
// bracketed by bisection and linearly interpolated with a truncating serial divide. An
// unknown table, equal neighbor keys, a failed search or a result outside
// [min_temp, max_temp] returns default_temp with used_default set on tuser. One request
// is handled at a time: after acceptance the block reads the table ends, runs at most 9
// bisection steps (a middle entry, then its neighbour), and when it interpolates loads
// the serial divider for the quotient bits and multiplies, then checks the range; ready
// returns the cycle after the result is taken. The serial divider and the single ROM
// read port set the conversion time.
module ntc_table_temperature_convert #(
  parameter int unsigned Scale = ntc_pkg::ScaleDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // [23:0] raw_sample
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // [19:0] temperature
  output logic               m_axis_tuser,   // [0] used_default
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i
);
  import ntc_pkg::*;

  localparam int unsigned SclW = $clog2(Scale + 1);
  localparam int unsigned NumW = KeyW + SclW + 1;
  localparam int unsigned ProdW = NumW + DegW + SclW + 2;
  localparam int unsigned MulW = DegW + SclW + 2;

  localparam logic [2:0] StIdle = 3'd0, StEnds = 3'd1, StMid = 3'd2, StNbr = 3'd3,
                         StDiv = 3'd4, StMul = 3'd5, StChk = 3'd6, StOut = 3'd7;

  logic [2:0]  st_q, st_d;
  logic [SelW-1:0] sel_q;
  logic signed [TempW-1:0] def_q, min_q, max_q;
  logic signed [RawW-1:0]  x_q;
  logic signed [IdxW+1:0]  lo_q, hi_q, mid_q, lo_d, hi_d, mid_d;
  logic [IdxW-1:0] ra;
  entry_t      re, mid_e_q;
  logic signed [ProdW-1:0] res_q, res_d;
  logic        fail_q, fail_d, ends_q, ends_d;
  entry_t      a_q, b_q, a_d, b_d, mid_e_d;
  logic        dstart;
  logic        ddone;
  logic [NumW-1:0] dnum, dquot;
  logic [IdxW:0] n;
  logic signed [RawW:0] kx;
  logic signed [DegW:0] ddeg;
  logic signed [MulW-1:0] dprod;
  logic        out_v_q;
  logic [TempW-1:0] out_t_q;
  logic        out_f_q;

  assign n  = tab_len(sel_q);
  assign ra = (st_q == StEnds && ends_q) ? IdxW'(n - 1'b1) : mid_q[IdxW-1:0];
  assign re = tab_entry(sel_q, ra);
  assign kx = $signed({2'b00, b_q.key}) - (RawW+1)'(x_q);
  assign dnum = NumW'(kx) * NumW'(Scale);

  // fraction is below Scale, so a narrow product is enough
  assign ddeg  = (DegW+1)'(a_q.deg) - (DegW+1)'(b_q.deg);
  assign dprod = ddeg * $signed({1'b0, dquot[SclW-1:0]});

  ntc_div #(.NumW(NumW), .DenW(KeyW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum),
    .den_i(b_q.key - a_q.key), .done_o(ddone), .quot_o(dquot)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      def_q <= TempW'(25000);
      min_q <= -TempW'(40000);
      max_q <= TempW'(125000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTableSel: sel_q <= cfg_wdata_i[SelW-1:0];
        RegDefault:  def_q <= cfg_wdata_i;
        RegMin:      min_q <= cfg_wdata_i;
        RegMax:      max_q <= cfg_wdata_i;
        default:     sel_q <= sel_q;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    st_d = st_q; lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    res_d = res_q; fail_d = fail_q; ends_d = ends_q;
    a_d = a_q; b_d = b_q; mid_e_d = mid_e_q; dstart = 1'b0;
    case (st_q)
      StIdle: if (s_axis_tvalid) begin
        st_d = (sel_q < NumTables) ? StEnds : StChk;
        fail_d = !(sel_q < NumTables);
        ends_d = 1'b0; mid_d = '0;
      end
      StEnds: begin
        // first pass reads entry 0, second reads the last entry
        if (!ends_q && $signed({1'b0, re.key}) > x_q) begin
          res_d = ProdW'(re.deg) * ProdW'(Scale); st_d = StChk;
        end else if (ends_q && $signed({1'b0, re.key}) < x_q) begin
          res_d = ProdW'(re.deg) * ProdW'(Scale); st_d = StChk;
        end else if (!ends_q) begin
          ends_d = 1'b1;
        end else begin
          lo_d = '0; hi_d = (IdxW+2)'(n);
          mid_d = (IdxW+2)'(n) >>> 1; st_d = StMid;
        end
      end
      StMid: begin
        mid_e_d = re;
        if (mid_q < 0 || mid_q >= $signed({1'b0, n})) begin
          fail_d = 1'b1; st_d = StChk;
        end else if ($signed({1'b0, re.key}) == x_q) begin
          res_d = ProdW'(re.deg) * ProdW'(Scale); st_d = StChk;
        end else begin
          mid_d = ($signed({1'b0, re.key}) > x_q) ? mid_q - (IdxW+2)'(1)
                                                   : mid_q + (IdxW+2)'(1);
          st_d = StNbr;
        end
      end
      StNbr: begin
        // mid_q now points at the neighbour; mid_e_q holds the middle entry
        if ($signed({1'b0, mid_e_q.key}) > x_q) begin
          if (mid_q >= 0 && $signed({1'b0, re.key}) < x_q) begin
            a_d = re; b_d = mid_e_q; st_d = StDiv;
          end else hi_d = mid_q;
          if (!(mid_q >= 0 && $signed({1'b0, re.key}) < x_q)) begin
            mid_d = (lo_q + mid_q) >>> 1;
            st_d = (lo_q <= mid_q) ? StMid : StChk;
            fail_d = !(lo_q <= mid_q);
          end
        end else begin
          if (mid_q < $signed({1'b0, n}) && $signed({1'b0, re.key}) > x_q) begin
            a_d = mid_e_q; b_d = re; st_d = StDiv;
          end else begin
            lo_d = mid_q;
            mid_d = (mid_q + hi_q) >>> 1;
            st_d = (mid_q <= hi_q) ? StMid : StChk;
            fail_d = !(mid_q <= hi_q);
          end
        end
        if (st_d == StDiv) begin
          if (a_d.key == b_d.key) begin
            fail_d = 1'b1; st_d = StChk;
          end
        end
      end
      StDiv: begin
        dstart = !ends_q;
        ends_d = 1'b1;
        if (ddone) st_d = StMul;
      end
      StMul: begin
        res_d = ProdW'(dprod) + ProdW'(b_q.deg) * ProdW'(Scale);
        st_d = StChk;
      end
      StChk: st_d = StOut;
      StOut: if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    if (st_q == StNbr && st_d == StDiv) ends_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StChk) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; res_q <= res_d;
    fail_q <= fail_d; ends_q <= ends_d; a_q <= a_d; b_q <= b_d; mid_e_q <= mid_e_d;
    if (st_q == StIdle) x_q <= s_axis_tdata;
    if (st_q == StChk) begin
      if (fail_q || res_q < ProdW'(min_q) || res_q > ProdW'(max_q)) begin
        out_t_q <= def_q; out_f_q <= 1'b1;
      end else begin
        out_t_q <= res_q[TempW-1:0]; out_f_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = st_q == StIdle;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0000, out_t_q};
  assign m_axis_tuser  = out_f_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_out_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q) == StChk) else $error("spurious result");
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddone |-> st_q == StDiv) else $error("divider done outside divide");
`endif
endmodule

FILE: dv/tb.sv
// Self-checking testbench for the NTC table temperature converter stream block.
module tb;
  import ntc_pkg::*;

  localparam int unsigned ScaleTb   = 1000;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldLen   = 400;

  typedef struct packed {
    logic [19:0] temp;
    logic        dflt;
  } temp_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [19:0] cfg_wdata_i;

  // shadow copy of the register file
  logic [2:0]  sel_reg;
  logic [19:0] dflt_reg, min_reg, max_reg;

  logic [23:0]  raw_q[$];
  temp_result_t temp_q[$];

  int  errors;
  int  n_sent, n_recv, n_dflt;
  int  src_gap;
  bit  src_no_idle, rx_no_idle;
  logic long_hold_req;
  int  hold_left;
  bit  hold_done;
  int  idle_cycles;

  ntc_table_temperature_convert dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ROM views of the selected thermistor table
  function automatic int tab_size(input logic [2:0] sel);
    case (sel)
      3'd0: return LenR;
      3'd1: return LenV10;
      3'd2: return LenV12;
      3'd3: return LenV18;
      default: return 0;
    endcase
  endfunction

  function automatic longint key_at(input logic [2:0] sel, input int i);
    case (sel)
      3'd0: return RKey[i];
      3'd1: return V10Key[i];
      3'd2: return V12Key[i];
      default: return V18Key[i];
    endcase
  endfunction

  function automatic longint deg_at(input logic [2:0] sel, input int i);
    if (sel == 3'd3) return V18Deg[i];
    return 125 - i;
  endfunction

  // linear interpolation between entries a and b; fails on equal keys
  function automatic bit interp_temp(input logic [2:0] sel, input int a, input int b,
                                     input longint x, output longint t);
    longint klo, khi, frac;
    klo = key_at(sel, a);
    khi = key_at(sel, b);
    t = 0;
    if (khi == klo) return 1'b0;
    frac = ((khi - x) * ScaleTb) / (khi - klo);
    t = (deg_at(sel, a) - deg_at(sel, b)) * frac + deg_at(sel, b) * ScaleTb;
    return 1'b1;
  endfunction

  // clamp at the ends, exact hit, or bisection plus interpolation
  function automatic bit lookup_temp(input logic [2:0] sel, input longint x,
                                     output longint t);
    int n, lo, hi, mid;
    n = tab_size(sel);
    lo = 0;
    hi = n;
    t = 0;
    if (x < key_at(sel, 0)) begin
      t = deg_at(sel, 0) * ScaleTb;
      return 1'b1;
    end
    if (x > key_at(sel, n - 1)) begin
      t = deg_at(sel, n - 1) * ScaleTb;
      return 1'b1;
    end
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (mid < 0 || mid >= n) return 1'b0;
      if (key_at(sel, mid) > x) begin
        if (mid >= 1 && key_at(sel, mid - 1) < x) return interp_temp(sel, mid - 1, mid, x, t);
        hi = mid - 1;
      end else if (key_at(sel, mid) < x) begin
        if (mid + 1 < n && key_at(sel, mid + 1) > x) return interp_temp(sel, mid, mid + 1, x, t);
        lo = mid + 1;
      end else begin
        t = deg_at(sel, mid) * ScaleTb;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic temp_result_t convert_reading(input logic [23:0] raw);
    temp_result_t r;
    longint t;
    bit ok;
    ok = 1'b0;
    t = 0;
    if (sel_reg < NumTables) ok = lookup_temp(sel_reg, longint'($signed(raw)), t);
    if (ok && (t < longint'($signed(min_reg)) || t > longint'($signed(max_reg)))) ok = 1'b0;
    r.temp = ok ? t[19:0] : dflt_reg;
    r.dflt = !ok;
    return r;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // random reading that favors table keys and their neighbors
  function automatic logic [23:0] rand_reading(input logic [2:0] sel);
    int n, r;
    logic [2:0] s;
    s = (sel < NumTables) ? sel : 3'($urandom_range(0, 3));
    n = tab_size(s);
    r = $urandom_range(0, 9);
    if (r < 3) return 24'(key_at(s, $urandom_range(0, n - 1)));
    if (r < 6) return 24'(key_at(s, $urandom_range(0, n - 1)) + $urandom_range(0, 40) - 20);
    if (r < 8) return 24'($urandom_range(0, int'(key_at(s, n - 1)) + 20));
    if (r < 9) return 24'($urandom_range(0, 24'h7fffff));
    return $urandom_range(0, 1) ? 24'hffffff : 24'h7fffff;
  endfunction

  // request source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        temp_q.push_back(convert_reading(s_axis_tdata));
        n_sent <= n_sent + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request
      end else if (src_gap > 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (raw_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw_q.pop_front();
        src_gap       <= src_no_idle ? 0 : next_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    temp_result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv <= n_recv + 1;
        if (temp_q.size() == 0) begin
          $display("%0t: result with nothing expected: temp=%0d dflt=%0b", $time,
                   $signed(m_axis_tdata[19:0]), m_axis_tuser);
          errors <= errors + 1;
        end else begin
          e = temp_q.pop_front();
          if (e.dflt) n_dflt <= n_dflt + 1;
          if (m_axis_tdata[19:0] !== e.temp || m_axis_tuser !== e.dflt) begin
            $display("%0t: mismatch: expected temp=%0d dflt=%0b, actual temp=%0d dflt=%0b",
                     $time, $signed(e.temp), e.dflt, $signed(m_axis_tdata[19:0]),
                     m_axis_tuser);
            errors <= errors + 1;
          end
        end
      end
      if (long_hold_req && !hold_done) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldLen;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!rx_no_idle && $urandom_range(0, 49) == 0) begin
        // occasional long pause on the result side
        hold_left     <= $urandom_range(8, 60);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rx_no_idle ? 1'b1 : ($urandom_range(0, 9) < 7);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // write all four registers in consecutive cycles
  task automatic write_regs(input logic [2:0] sel, input int dflt, input int lo, input int hi);
    logic [19:0] vals[4];
    vals[RegTableSel] = 20'(sel);
    vals[RegDefault]  = 20'(dflt);
    vals[RegMin]      = 20'(lo);
    vals[RegMax]      = 20'(hi);
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 2'(i);
      cfg_wdata_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sel_reg  = sel;
    dflt_reg = vals[RegDefault];
    min_reg  = vals[RegMin];
    max_reg  = vals[RegMax];
  endtask

  task automatic drain();
    wait (raw_q.size() == 0 && !s_axis_tvalid && temp_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) raw_q.push_back(rand_reading(sel_reg));
    drain();
  endtask

  initial begin
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    n_dflt = 0;
    idle_cycles = 0;
    src_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    long_hold_req = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegTableSel;
    cfg_wdata_i = '0;
    sel_reg = 3'd0;
    dflt_reg = 20'(25000);
    min_reg = 20'(-40000);
    max_reg = 20'(125000);
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, table ends, exact keys, duplicate keys, read failure
    raw_q = '{24'hffffff, 24'h000000, 24'h7fffff, 24'h800000, 24'd2560, 24'd2561,
              24'd4251000, 24'd4251001, 24'd3966, 24'd3965, 24'd3967, 24'd4000,
              24'd100000, 24'd100001, 24'd355600, 24'd4000000, 24'd2600, 24'h555555,
              24'haaaaaa};
    drain();

    // table with non-monotonic keys around the second entry
    write_regs(3'd1, -300000, -300000, 300000);
    raw_q = '{24'd207, 24'd208, 24'd217, 24'd218, 24'd219, 24'd3890, 24'd3891, 24'd2000};
    drain();
    run_random(220);

    // table with a zero entry and a deep cold end; long receiver hold-off
    write_regs(3'd3, 300000, -300000, 300000);
    raw_q = '{24'hffffff, 24'd0, 24'd50, 24'd4095, 24'd4096, 24'd3900};
    src_no_idle = 1'b1;
    @(posedge clk_i);
    long_hold_req <= 1'b1;
    drain();
    run_random(200);
    src_no_idle = 1'b0;

    write_regs(3'd2, 0, -300000, 300000);
    raw_q = '{24'd464, 24'd475, 24'd486, 24'd487, 24'd174, 24'd3852};
    rx_no_idle = 1'b1;
    drain();
    run_random(200);
    rx_no_idle = 1'b0;

    write_regs(3'd0, 12345, -300000, 300000);
    run_random(220);

    // unknown tables
    write_regs(3'd4, -1, -300000, 300000);
    run_random(80);
    write_regs(3'd7, 524287 - 224288, -300000, 300000);
    run_random(80);

    // inverted limits
    write_regs(3'd0, -300000, 300000, -300000);
    run_random(120);

    // narrow windows that reject part of the range
    write_regs(3'd1, 1000, 20000, 60000);
    run_random(220);
    write_regs(3'd2, -5000, -10000, 10000);
    run_random(220);
    write_regs(3'd3, 77, 0, 0);
    run_random(180);
    write_regs(3'd0, 25000, -40000, 125000);
    run_random(220);

    repeat (100) @(posedge clk_i);
    $display("Covered %0d readings over four tables and unknown selectors, %0d results,",
             n_sent, n_recv);
    $display("%0d of them with the fallback temperature, under several limit windows.",
             n_dflt);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: ntc_table_temperature_convert.f
rtl/ntc_pkg.sv
rtl/ntc_div.sv
rtl/ntc_table_temperature_convert.sv
dv/tb.sv
